// ===== hdl/midpoint_ellipse_tracer_macros.svh =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_tracer_macros.svh
// Assertion helpers used by the tracer RTL.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_TRACER_MACROS_SVH
`define MIDPOINT_ELLIPSE_TRACER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define MET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Types, constants and microcode ROM of the midpoint ellipse tracer.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int CENTER_W        = 10;
  localparam int COORD_W         = 12;
  localparam int CFG_ADDR_W      = 2;
  localparam int IN_DATA_W       = 8;
  localparam int OUT_DATA_W      = 4 * COORD_W;

  // register reset values
  localparam int RX_RESET = 100;
  localparam int RY_RESET = 50;
  localparam int CX_RESET = 350;
  localparam int CY_RESET = 350;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RADIUS_X = 2'd0,
    CFG_RADIUS_Y = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_reg_t;

  // trace phase, one-hot
  typedef enum logic [2:0] {
    PH_DONE = 3'b001,
    PH_R1   = 3'b010,
    PH_R2   = 3'b100
  } phase_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_RY2_X,
    MUL_RX2_Y,
    MUL_TY_TY,
    MUL_TX_TX,
    MUL_RX2_T,
    MUL_RY2_T,
    MUL_RX2_RY2,
    MUL_RY2_XP1
  } mul_sel_t;

  // datapath register transfers
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LD_RX2,
    ALU_LD_RY2,
    ALU_INIT,
    ALU_LD_T,
    ALU_T_R1,
    ALU_R1_STEP,
    ALU_D_LD4P,
    ALU_D_ADDP,
    ALU_D_SUB4P,
    ALU_D_DIV4,
    ALU_Y_DEC,
    ALU_T_R2,
    ALU_R2_STEP
  } alu_op_t;

  // result word kinds
  typedef enum logic [1:0] {
    EM_NONE,
    EM_MID,
    EM_CHK,
    EM_ZERO
  } emit_t;

  // sequencer jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_WAIT,
    JC_DISPATCH,
    JC_R1_STOP,
    JC_R2_STOP
  } jcond_t;

  typedef logic [4:0] uaddr_t;

  // microprogram addresses
  localparam uaddr_t UA_IDLE  = 5'd0;
  localparam uaddr_t UA_SQ_X  = 5'd1;
  localparam uaddr_t UA_SQ_Y  = 5'd2;
  localparam uaddr_t UA_DISP  = 5'd3;
  localparam uaddr_t UA_RST   = 5'd4;
  localparam uaddr_t UA_R1_A  = 5'd5;
  localparam uaddr_t UA_R1_B  = 5'd6;
  localparam uaddr_t UA_R1_C  = 5'd7;
  localparam uaddr_t UA_R1_D  = 5'd8;
  localparam uaddr_t UA_SW_A  = 5'd9;
  localparam uaddr_t UA_SW_B  = 5'd10;
  localparam uaddr_t UA_SW_C  = 5'd11;
  localparam uaddr_t UA_SW_D  = 5'd12;
  localparam uaddr_t UA_SW_E  = 5'd13;
  localparam uaddr_t UA_SW_F  = 5'd14;
  localparam uaddr_t UA_SW_G  = 5'd15;
  localparam uaddr_t UA_R2_A  = 5'd16;
  localparam uaddr_t UA_R2_B  = 5'd17;
  localparam uaddr_t UA_R2_C  = 5'd18;
  localparam uaddr_t UA_R2_D  = 5'd19;
  localparam uaddr_t UA_ZERO  = 5'd20;

  typedef struct packed {
    mul_sel_t mul;
    alu_op_t  alu;
    emit_t    emit;
    jcond_t   jc;
    uaddr_t   target;
  } ucw_t;

  // Microcode ROM
  function automatic ucw_t ucode(input uaddr_t a);
    ucw_t w;
    w = '{mul: MUL_NONE, alu: ALU_NOP, emit: EM_NONE, jc: JC_NEXT, target: UA_IDLE};
    case (a)
      UA_IDLE: w.jc = JC_WAIT;
      UA_SQ_X: w.mul = MUL_RX_RX;
      UA_SQ_Y: begin
        w.mul = MUL_RY_RY;
        w.alu = ALU_LD_RX2;
      end
      UA_DISP: begin
        w.mul = MUL_RX2_RY;
        w.alu = ALU_LD_RY2;
        w.jc  = JC_DISPATCH;
      end
      // restart: start point
      UA_RST: begin
        w.alu  = ALU_INIT;
        w.emit = EM_MID;
        w.jc   = JC_GOTO;
      end
      // region 1: boundary test products
      UA_R1_A: w.mul = MUL_RY2_X;
      UA_R1_B: begin
        w.mul = MUL_RX2_Y;
        w.alu = ALU_LD_T;
      end
      UA_R1_C: begin
        w.alu    = ALU_T_R1;
        w.jc     = JC_R1_STOP;
        w.target = UA_SW_A;
      end
      UA_R1_D: begin
        w.alu  = ALU_R1_STEP;
        w.emit = EM_MID;
        w.jc   = JC_GOTO;
      end
      // switch to region 2: exact start decision
      UA_SW_A: w.mul = MUL_TY_TY;
      UA_SW_B: begin
        w.mul = MUL_TX_TX;
        w.alu = ALU_LD_T;
      end
      UA_SW_C: begin
        w.mul = MUL_RX2_T;
        w.alu = ALU_LD_T;
      end
      UA_SW_D: begin
        w.mul = MUL_RY2_T;
        w.alu = ALU_D_LD4P;
      end
      UA_SW_E: begin
        w.mul = MUL_RX2_RY2;
        w.alu = ALU_D_ADDP;
      end
      UA_SW_F: w.alu = ALU_D_SUB4P;
      UA_SW_G: begin
        w.alu  = ALU_D_DIV4;
        w.emit = EM_CHK;
        w.jc   = JC_GOTO;
      end
      // region 2
      UA_R2_A: begin
        w.jc     = JC_R2_STOP;
        w.target = UA_ZERO;
      end
      UA_R2_B: begin
        w.mul = MUL_RX2_Y;
        w.alu = ALU_Y_DEC;
      end
      UA_R2_C: begin
        w.mul = MUL_RY2_XP1;
        w.alu = ALU_T_R2;
      end
      UA_R2_D: begin
        w.alu  = ALU_R2_STEP;
        w.emit = EM_CHK;
        w.jc   = JC_GOTO;
      end
      UA_ZERO: begin
        w.emit = EM_ZERO;
        w.jc   = JC_GOTO;
      end
      default: w.jc = JC_GOTO;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/midpoint_ellipse_tracer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_tracer
// Microcoded midpoint ellipse tracer: one point set per input word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            word
//  in_      in   in_tvalid/in_tready   tdata[0] restart
//  out_     out  out_tvalid/out_tready tdata 4 coords, tuser valid, tlast last
//  cfg_     in   cfg_we                cfg_addr register, cfg_data value
//
//  From accept to result register the microprogram runs the restart step, the
//  zero step for an advance after the end, the loop test and zero step for a
//  region-2 advance whose loop is already over, a region step, or the switch
//  into region 2, and then goes back to the idle step before the next accept.
//  The shared multiplier sets these steps; one item is in work at a time.
//  A result waiting in the output register stalls only the step that emits.
//  Reset: synchronous, active low; trace finished, registers at defaults.
//
`include "midpoint_ellipse_tracer_macros.svh"

module midpoint_ellipse_tracer
  import met_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // fields from bit 0: restart, zero fill
  input  logic [IN_DATA_W-1:0]          in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fields from bit 0: right_x, left_x, upper_y, lower_y
  output logic [OUT_DATA_W-1:0]         out_tdata,
  // fields from bit 0: point_valid
  output logic                          out_tuser,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [((RADIUS_BITS > CENTER_W) ? RADIUS_BITS : CENTER_W)-1:0] cfg_data
);

  localparam int XW  = RADIUS_BITS + 1;       // x offset, unsigned
  localparam int YW  = RADIUS_BITS + 1;       // y offset, signed, may reach -1
  localparam int SQW = 2 * RADIUS_BITS;       // squared radius
  localparam int MW  = 2 * RADIUS_BITS + 4;   // multiplier operand
  localparam int DW  = 2 * MW;                // product and decision

  // configuration registers
  logic [RADIUS_BITS-1:0] rx_r, ry_r;
  logic [CENTER_W-1:0]    cx_r, cy_r;

  // sequencer
  uaddr_t upc_r, upc_nxt;
  ucw_t   uw;
  phase_t phase_r, phase_nxt;
  logic   restart_r;
  logic   in_fire, hold, step_run, out_load;

  // datapath
  logic        [XW-1:0]  x_r, x_nxt;
  logic signed [YW-1:0]  y_r, y_nxt;
  logic signed [DW-1:0]  d_r, d_nxt, t_r, t_nxt, p_r, dq;
  logic        [SQW-1:0] rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic signed [DW-1:0]  rx2_s, ry2_s;
  logic        [MW-1:0]  mul_a, mul_b;
  logic        [DW-1:0]  prod;
  logic signed [YW:0]    ym1;
  logic        [YW-1:0]  ty_mag;
  logic                  r1_stop, r2_stop, last_chk;

  // result register
  logic                  out_tvalid_r, out_valid_r, out_last_r;
  logic [COORD_W-1:0]    right_x_r, left_x_r, upper_y_r, lower_y_r;
  logic [COORD_W-1:0]    cx12, cy12, x12, y12;
  logic                  end_load, idle_word;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= RADIUS_BITS'(RX_RESET);
      ry_r <= RADIUS_BITS'(RY_RESET);
      cx_r <= CENTER_W'(CX_RESET);
      cy_r <= CENTER_W'(CY_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_RADIUS_X: rx_r <= cfg_data[RADIUS_BITS-1:0];
        CFG_RADIUS_Y: ry_r <= cfg_data[RADIUS_BITS-1:0];
        CFG_CENTER_X: cx_r <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y: cy_r <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Control word and handshake
  assign uw        = ucode(upc_r);
  assign in_tready = (upc_r == UA_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign hold      = (uw.emit != EM_NONE) && out_tvalid_r && !out_tready;
  assign step_run  = !hold;
  assign out_load  = step_run && (uw.emit != EM_NONE);

  // Signed views of the squared radii
  assign rx2_s = signed'(DW'(rx2_r));
  assign ry2_s = signed'(DW'(ry2_r));

  // |y - 1| for the switch decision
  assign ym1    = {y_r[YW-1], y_r} - {{YW{1'b0}}, 1'b1};
  assign ty_mag = YW'(ym1[YW] ? (~ym1 + 1'b1) : ym1);

  // Loop tests
  assign r1_stop = y_r[YW-1] || (t_r > p_r);
  assign r2_stop = !((y_r > 0) && (x_r <= XW'(rx_r)));

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul)
      MUL_RX_RX:   begin mul_a = MW'(rx_r);  mul_b = MW'(rx_r); end
      MUL_RY_RY:   begin mul_a = MW'(ry_r);  mul_b = MW'(ry_r); end
      MUL_RX2_RY:  begin mul_a = MW'(rx2_r); mul_b = MW'(ry_r); end
      MUL_RY2_X:   begin mul_a = MW'(ry2_r); mul_b = MW'(x_r); end
      MUL_RX2_Y:   begin mul_a = MW'(rx2_r); mul_b = MW'(y_r[RADIUS_BITS-1:0]); end
      MUL_TY_TY:   begin mul_a = MW'(ty_mag); mul_b = MW'(ty_mag); end
      MUL_TX_TX:   begin mul_a = MW'({x_r, 1'b1}); mul_b = MW'({x_r, 1'b1}); end
      MUL_RX2_T:   begin mul_a = MW'(rx2_r); mul_b = t_r[MW-1:0]; end
      MUL_RY2_T:   begin mul_a = MW'(ry2_r); mul_b = t_r[MW-1:0]; end
      MUL_RX2_RY2: begin mul_a = MW'(rx2_r); mul_b = MW'(ry2_r); end
      MUL_RY2_XP1: begin mul_a = MW'(ry2_r); mul_b = MW'(x_r) + MW'(1); end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Datapath register transfers
  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    d_nxt   = d_r;
    t_nxt   = t_r;
    rx2_nxt = rx2_r;
    ry2_nxt = ry2_r;
    dq      = d_r + signed'(DW'(3));
    case (uw.alu)
      ALU_LD_RX2: rx2_nxt = p_r[SQW-1:0];
      ALU_LD_RY2: ry2_nxt = p_r[SQW-1:0];
      ALU_INIT: begin
        x_nxt = '0;
        y_nxt = signed'({1'b0, ry_r});
        d_nxt = ry2_s - p_r + (rx2_s >>> 2);
      end
      ALU_LD_T: t_nxt = p_r;
      // 2*ry2*x + 3*ry2, plus 2*rx2 when y steps down
      ALU_T_R1: t_nxt = (t_r <<< 1) + ry2_s + (ry2_s <<< 1)
                        + (d_r[DW-1] ? '0 : (rx2_s <<< 1));
      ALU_R1_STEP: begin
        x_nxt = x_r + XW'(1);
        if (d_r[DW-1]) begin
          d_nxt = d_r + t_r;
        end else begin
          y_nxt = y_r - YW'(1);
          d_nxt = d_r + t_r - (p_r <<< 1);
        end
      end
      ALU_D_LD4P:  d_nxt = p_r <<< 2;
      ALU_D_ADDP:  d_nxt = d_r + p_r;
      ALU_D_SUB4P: d_nxt = d_r - (p_r <<< 2);
      // divide by four, truncating toward zero
      ALU_D_DIV4:  d_nxt = d_r[DW-1] ? (dq >>> 2) : (d_r >>> 2);
      ALU_Y_DEC:   y_nxt = y_r - YW'(1);
      // rx2 * (1 - 2*y) after the decrement
      ALU_T_R2:    t_nxt = rx2_s + (rx2_s <<< 1) - (p_r <<< 1);
      ALU_R2_STEP: begin
        if (d_r[DW-1]) begin
          x_nxt = x_r + XW'(1);
          d_nxt = d_r + t_r + (p_r <<< 1);
        end else begin
          d_nxt = d_r + t_r;
        end
      end
      default: ;
    endcase
  end

  assign last_chk = !((y_nxt > 0) && (x_nxt <= XW'(rx_r)));

  // Phase update
  always_comb begin
    phase_nxt = phase_r;
    if (uw.alu == ALU_INIT) begin
      phase_nxt = PH_R1;
    end
    case (uw.emit)
      EM_CHK:  phase_nxt = last_chk ? PH_DONE : PH_R2;
      EM_ZERO: phase_nxt = PH_DONE;
      default: ;
    endcase
  end

  // Step counter and jumps
  always_comb begin
    upc_nxt = upc_r + uaddr_t'(1);
    case (uw.jc)
      JC_NEXT: upc_nxt = upc_r + uaddr_t'(1);
      JC_GOTO: upc_nxt = uw.target;
      JC_WAIT: upc_nxt = in_fire ? (upc_r + uaddr_t'(1)) : upc_r;
      JC_DISPATCH: begin
        if (restart_r) begin
          upc_nxt = UA_RST;
        end else begin
          case (phase_r)
            PH_R1:   upc_nxt = UA_R1_A;
            PH_R2:   upc_nxt = UA_R2_A;
            default: upc_nxt = UA_ZERO;
          endcase
        end
      end
      JC_R1_STOP: upc_nxt = r1_stop ? uw.target : (upc_r + uaddr_t'(1));
      JC_R2_STOP: upc_nxt = r2_stop ? uw.target : (upc_r + uaddr_t'(1));
      default: upc_nxt = UA_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= UA_IDLE;
      phase_r <= PH_DONE;
    end else if (step_run) begin
      upc_r   <= upc_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      restart_r <= in_tdata[0];
    end
    if (step_run) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      d_r   <= d_nxt;
      t_r   <= t_nxt;
      rx2_r <= rx2_nxt;
      ry2_r <= ry2_nxt;
      if (uw.mul != MUL_NONE) begin
        p_r <= signed'(prod);
      end
    end
  end

  // Point set from the updated offsets, wrapped to 12 bits
  assign cx12 = COORD_W'(cx_r);
  assign cy12 = COORD_W'(cy_r);
  assign x12  = COORD_W'(x_nxt);
  assign y12  = COORD_W'(y_nxt);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (uw.emit == EM_ZERO) begin
        out_valid_r <= 1'b0;
        out_last_r  <= 1'b0;
        right_x_r   <= '0;
        left_x_r    <= '0;
        upper_y_r   <= '0;
        lower_y_r   <= '0;
      end else begin
        out_valid_r <= 1'b1;
        out_last_r  <= (uw.emit == EM_CHK) && last_chk;
        right_x_r   <= cx12 + x12;
        left_x_r    <= cx12 - x12;
        upper_y_r   <= cy12 + y12;
        lower_y_r   <= cy12 - y12;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {lower_y_r, upper_y_r, left_x_r, right_x_r};

  // Checks
  assign end_load  = out_load && (uw.emit == EM_CHK) && last_chk;
  assign idle_word = out_tvalid && !out_tuser;

  `MET_ASSERT_NEXT(a_accept_starts, in_fire, upc_r == UA_SQ_X, "sequencer did not start")
  `MET_ASSERT_NEXT(a_hold_keeps_step, hold, $stable(upc_r), "step moved while result blocked")
  `MET_ASSERT_NEXT(a_last_ends_trace, end_load, phase_r == PH_DONE, "trace not finished")
  `MET_ASSERT_SAME(a_idle_word_zero, idle_word, !(|out_tdata) && !out_tlast, "idle word not zero")

endmodule

// ===== tb/sv/midpoint_ellipse_tracer_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_tracer_tb
// Self-checking bench for the midpoint ellipse tracer.
// Sends restart and advance words under random flow control on both sides.
// An in-bench model of the integer midpoint ellipse trace predicts each point
// set, and every result word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module midpoint_ellipse_tracer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import met_pkg::*;

  localparam int CFG_W         = (RADIUS_BITS_DEF > CENTER_W) ? RADIUS_BITS_DEF : CENTER_W;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int TRACE_CAP     = 300;
  localparam int MAX_REPORTS   = 100;

  typedef struct {
    logic               valid;
    logic [COORD_W-1:0] right_x;
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] upper_y;
    logic [COORD_W-1:0] lower_y;
    logic               last;
  } point_set_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  cfg_reg_t              cfg_addr;
  logic [CFG_W-1:0]      cfg_data;

  midpoint_ellipse_tracer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),    // bit 0: restart
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),   // right_x, left_x, upper_y, lower_y
    .out_tuser (out_tuser),   // point_valid
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // flow control knobs and bookkeeping
  bit         src_idle   = 1'b1;
  bit         sink_idle  = 1'b1;
  int         sink_hold  = 0;
  int         items_sent = 0;
  int         mismatches = 0;
  point_set_t expected_points[$];

  // tracer state as the bench sees it
  logic [RADIUS_BITS_DEF-1:0] rad_x = RADIUS_BITS_DEF'(RX_RESET);
  logic [RADIUS_BITS_DEF-1:0] rad_y = RADIUS_BITS_DEF'(RY_RESET);
  logic [CENTER_W-1:0]        ctr_x = CENTER_W'(CX_RESET);
  logic [CENTER_W-1:0]        ctr_y = CENTER_W'(CY_RESET);
  longint                     off_x = 0;
  longint                     off_y = 0;
  logic [63:0]                decision_acc = '0;
  phase_t                     trc_phase = PH_DONE;

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : run_limit
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit region2_active();
    return off_y > 0 && off_x <= longint'(rad_x);
  endfunction

  // four mirrored points around the center for the current offset
  function automatic point_set_t place_points(input bit last);
    point_set_t p;
    logic [63:0] ux, uy;
    ux = off_x;
    uy = off_y;
    p.valid   = 1'b1;
    p.right_x = COORD_W'(64'(ctr_x) + ux);
    p.left_x  = COORD_W'(64'(ctr_x) - ux);
    p.upper_y = COORD_W'(64'(ctr_y) + uy);
    p.lower_y = COORD_W'(64'(ctr_y) - uy);
    p.last    = last;
    return p;
  endfunction

  // one restart or advance word; all arithmetic wraps at 64 bits
  function automatic point_set_t predict_point_set(input bit restart);
    point_set_t pt;
    logic [63:0] rx2, ry2, ux, uy, tx, ty, q, stp;
    bit fin;
    rx2 = 64'(rad_x) * 64'(rad_x);
    ry2 = 64'(rad_y) * 64'(rad_y);
    pt  = '{default: '0};
    if (restart) begin
      off_x        = 0;
      off_y        = longint'(rad_y);
      decision_acc = ry2 - rx2 * 64'(rad_y) + rx2 / 64'd4;
      trc_phase    = PH_R1;
      return place_points(1'b0);
    end
    ux = off_x;
    uy = off_y;
    case (trc_phase)
      PH_R1: begin
        if (off_y >= 0 && ry2 * ux <= rx2 * uy) begin
          off_x++;
          ux = off_x;
          if (decision_acc[63]) begin
            decision_acc += ry2 + 64'd2 * ry2 * ux;
          end else begin
            off_y--;
            uy = off_y;
            decision_acc += ry2 * (64'd2 * ux + 64'd1) - 64'd2 * rx2 * uy;
          end
          pt = place_points(1'b0);
        end else begin
          // switch to region 2: exact start term, truncated toward zero
          tx = 64'd2 * ux + 64'd1;
          ty = uy - 64'd1;
          q  = ry2 * tx * tx + 64'd4 * rx2 * ty * ty - 64'd4 * rx2 * ry2;
          if (q[63]) decision_acc = 64'd0 - ((64'd0 - q) / 64'd4);
          else decision_acc = q / 64'd4;
          fin       = !region2_active();
          trc_phase = fin ? PH_DONE : PH_R2;
          pt        = place_points(fin);
        end
      end
      PH_R2: begin
        if (!region2_active()) begin
          // entered with the loop already over: zero word
          trc_phase = PH_DONE;
        end else begin
          off_y--;
          uy  = off_y;
          stp = rx2 * (64'd1 - 64'd2 * uy);
          if (decision_acc[63]) begin
            off_x++;
            ux = off_x;
            decision_acc += stp + 64'd2 * ry2 * ux;
          end else begin
            decision_acc += stp;
          end
          fin = !region2_active();
          if (fin) trc_phase = PH_DONE;
          pt = place_points(fin);
        end
      end
      default: ;
    endcase
    return pt;
  endfunction

  // ----------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                      input logic [COORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      // keep the log bounded on a badly broken block
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
    end
  endfunction

  always @(posedge clk) begin : result_check
    point_set_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.valid   = out_tuser;
      got.right_x = out_tdata[COORD_W-1:0];
      got.left_x  = out_tdata[2*COORD_W-1:COORD_W];
      got.upper_y = out_tdata[3*COORD_W-1:2*COORD_W];
      got.lower_y = out_tdata[4*COORD_W-1:3*COORD_W];
      got.last    = out_tlast;
      if (expected_points.size() == 0) begin
        mismatches++;
        $error("result word with no expectation pending");
      end else begin
        want = expected_points.pop_front();
        check_field("point_valid", COORD_W'(want.valid), COORD_W'(got.valid));
        check_field("right_x", want.right_x, got.right_x);
        check_field("left_x", want.left_x, got.left_x);
        check_field("upper_y", want.upper_y, got.upper_y);
        check_field("lower_y", want.lower_y, got.lower_y);
        check_field("last_point", COORD_W'(want.last), COORD_W'(got.last));
      end
    end
  end

  // result side: random gap before each word, plus a long hold on request
  initial begin : result_sink
    int gap;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = sink_idle ? $urandom_range(0, 4) : 0;
      if (sink_hold > 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic send_word(input bit restart);
    int gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(restart);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_points.push_back(predict_point_set(restart));
    items_sent++;
  endtask

  // stop offering and wait until the block has delivered everything
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    logic [CFG_W-1:0] v;
    v = CFG_W'(value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RADIUS_X: rad_x = v[RADIUS_BITS_DEF-1:0];
      CFG_RADIUS_Y: rad_y = v[RADIUS_BITS_DEF-1:0];
      CFG_CENTER_X: ctr_x = v[CENTER_W-1:0];
      CFG_CENTER_Y: ctr_y = v[CENTER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ellipse(input int unsigned rx, input int unsigned ry,
                             input int unsigned cx, input int unsigned cy);
    drain_results();
    write_reg(CFG_RADIUS_X, rx);
    write_reg(CFG_RADIUS_Y, ry);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
  endtask

  // advance until the trace ends; optionally slip in a stray restart
  task automatic advance_until_done(input int cap, input bit noisy);
    int n;
    n = 0;
    while (trc_phase != PH_DONE && n < cap) begin
      send_word(noisy && $urandom_range(0, 59) == 0);
      n++;
    end
  endtask

  // mostly small radii, with the extremes and a few wide ones
  function automatic int unsigned pick_radius();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r == 1) return 1023;
    if (r == 2) return $urandom_range(0, 1023);
    return $urandom_range(1, 40);
  endfunction

  function automatic int unsigned pick_center();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return 1023;
    return $urandom_range(0, 1023);
  endfunction

  // -------------------------------------------------------------------- tests

  // advances before any restart give all-zero words
  task automatic test_idle_advance();
    send_word(1'b0);
    send_word(1'b0);
  endtask

  task automatic test_reset_defaults();
    send_word(1'b1);
    send_word(1'b0);
  endtask

  // both radii zero: (0,0), (1,-1), then (1,-1) again as the last point
  task automatic test_zero_radii();
    set_ellipse(0, 0, 200, 300);
    send_word(1'b1);
    advance_until_done(10, 1'b0);
    send_word(1'b0);
  endtask

  // zero vertical radius at the origin: y dips to -1, coordinates go negative
  task automatic test_flat_ellipse();
    set_ellipse(5, 0, 0, 0);
    send_word(1'b1);
    advance_until_done(10, 1'b0);
    send_word(1'b0);
  endtask

  task automatic test_extreme_registers();
    set_ellipse(1023, 1023, 1023, 1023);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    set_ellipse(0, 1023, 1023, 0);
    send_word(1'b1);
    advance_until_done(10, 1'b0);
  endtask

  // shrink radius_x right after the switch so region 2 starts already over
  task automatic test_region2_entry_cut();
    int n;
    set_ellipse(8, 8, 500, 20);
    send_word(1'b1);
    n = 0;
    while (trc_phase == PH_R1 && n < 40) begin
      send_word(1'b0);
      n++;
    end
    drain_results();
    write_reg(CFG_RADIUS_X, 0);
    send_word(1'b0);
    send_word(1'b0);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    set_ellipse(30, 20, 400, 600);
    src_idle = 1'b0;
    send_word(1'b1);
    sink_hold = 80;
    repeat (25) send_word(1'b0);
    src_idle = 1'b1;
  endtask

  // sender pauses mid-trace until every result is back, then resumes
  task automatic test_source_pause();
    set_ellipse(12, 9, 64, 900);
    send_word(1'b1);
    repeat (5) send_word(1'b0);
    drain_results();
    advance_until_done(TRACE_CAP, 1'b0);
    send_word(1'b0);
  endtask

  task automatic test_random_traces();
    int          start_cnt;
    int unsigned rx, ry;
    bit          wide;
    cfg_reg_t    idx;
    start_cnt = items_sent;
    while (items_sent - start_cnt < RANDOM_ITEMS) begin
      rx   = pick_radius();
      ry   = pick_radius();
      wide = rx > 64 || ry > 64;
      set_ellipse(rx, ry, pick_center(), pick_center());
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary restarts and advances
        repeat ($urandom_range(1, 20)) send_word($urandom_range(0, 3) == 0);
      end else begin
        send_word(1'b1);
        if (wide) begin
          // long traces are cut short
          advance_until_done($urandom_range(10, 50), 1'b1);
        end else begin
          if ($urandom_range(0, 7) == 0) begin
            // live register change in the middle of a trace
            advance_until_done($urandom_range(1, 15), 1'b1);
            drain_results();
            idx = cfg_reg_t'($urandom_range(0, 3));
            write_reg(idx, (idx == CFG_RADIUS_X || idx == CFG_RADIUS_Y) ?
                           pick_radius() : pick_center());
          end
          advance_until_done(TRACE_CAP, 1'b1);
        end
        repeat ($urandom_range(0, 2)) send_word(1'b0);
      end
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // --------------------------------------------------------------------- main

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_RADIUS_X;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_advance();
    test_reset_defaults();
    test_zero_radii();
    test_flat_ellipse();
    test_extreme_registers();
    test_region2_entry_cut();
    test_output_backpressure();
    test_source_pause();
    test_random_traces();

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/met_pkg.sv
hdl/midpoint_ellipse_tracer.sv
tb/sv/midpoint_ellipse_tracer_tb.sv
